### src/bbsf_pkg.sv
// Package for the bounded byte stream FIFO: opcodes, field widths and the
// command and status structs between controller and datapath. No dependencies.
package bbsf_pkg;

    localparam int BYTE_W = 8;
    localparam int CAP_W  = 13;
    localparam int TOT_W  = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLOSE = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic exec;     // apply the accepted operation to the stream state
        logic rd_en;    // read the front byte at the current head
        logic load;     // capture the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free; // output register is empty or is being taken now
    } t_dp_status;

endpackage

### src/bbsf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/bbsf_ctrl.sv
// Sequencer for the byte stream FIFO: execute, read front byte, load result.
// Depends on bbsf_pkg.
module bbsf_ctrl
    import bbsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cmd.exec  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd_en = (r_state == S_READ);
    assign o_cmd.load  = (r_state == S_LOAD) && i_status.out_free;

endmodule

### src/bbsf_dpath.sv
// Datapath of the byte stream FIFO: ring pointers, counters, flags, capacity
// register, byte storage and output register. Depends on bbsf_pkg, bbsf_ram.
module bbsf_dpath
    import bbsf_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [1:0]        i_opcode,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [CAP_W-1:0]  i_pop_length,
    input  logic              i_cfg_wr,
    input  logic [CAP_W-1:0]  i_cfg_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_front_byte,
    output logic              o_front_valid,
    output logic              o_accepted,
    output logic [CAP_W-1:0]  o_buffered_count,
    output logic [CAP_W-1:0]  o_free_space,
    output logic [TOT_W-1:0]  o_pushed_total,
    output logic [TOT_W-1:0]  o_popped_total,
    output logic              o_closed,
    output logic              o_finished,
    output logic              o_error
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);

    // Offset never exceeds the depth, so one conditional subtract wraps it.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offset);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(offset);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_fill;
    logic [TOT_W-1:0] r_pushed;
    logic [TOT_W-1:0] r_popped;
    logic             r_closed;
    logic             r_error;
    logic             r_accepted;
    logic [CAP_W-1:0] r_capacity;

    logic [AW-1:0]    n_head;
    logic [CW-1:0]    n_fill;
    logic [TOT_W-1:0] n_pushed;
    logic [TOT_W-1:0] n_popped;
    logic             n_closed;
    logic             n_error;
    logic             n_accepted;

    logic [EW-1:0]     eff_cap;
    logic [EW-1:0]     fill_e;
    logic [EW-1:0]     want_e;
    logic [EW-1:0]     pop_n_e;
    logic [EW-1:0]     free_e;
    logic              has_room;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] rd_data;
    t_opcode           op;

    assign op       = t_opcode'(i_opcode);
    assign eff_cap  = (EW'(r_capacity) > DEPTH_E) ? DEPTH_E : EW'(r_capacity);
    assign fill_e   = EW'(r_fill);
    assign want_e   = EW'(i_pop_length);
    assign pop_n_e  = (want_e < fill_e) ? want_e : fill_e;
    assign has_room = (eff_cap > fill_e);
    assign free_e   = has_room ? (eff_cap - fill_e) : '0;
    assign wr_addr  = ring_add(r_head, r_fill);

    always_comb begin
        n_head     = r_head;
        n_fill     = r_fill;
        n_pushed   = r_pushed;
        n_popped   = r_popped;
        n_closed   = r_closed;
        n_error    = r_error;
        n_accepted = 1'b0;
        wr_en      = 1'b0;
        if (i_cmd.exec) begin
            case (op)
                OP_PUSH: begin
                    if (r_closed) begin
                        n_error = 1'b1;
                    end else if (has_room) begin
                        wr_en      = 1'b1;
                        n_fill     = r_fill + 1'b1;
                        n_pushed   = r_pushed + 1'b1;
                        n_accepted = 1'b1;
                    end
                end
                OP_POP: begin
                    n_head   = ring_add(r_head, CW'(pop_n_e));
                    n_fill   = r_fill - CW'(pop_n_e);
                    n_popped = r_popped + TOT_W'(pop_n_e);
                end
                OP_CLOSE: begin
                    n_closed = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_fill     <= '0;
            r_pushed   <= '0;
            r_popped   <= '0;
            r_closed   <= 1'b0;
            r_error    <= 1'b0;
            r_accepted <= 1'b0;
            r_capacity <= CAP_RESET;
        end else begin
            if (i_cmd.exec) begin
                r_accepted <= n_accepted;
            end
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_pushed <= n_pushed;
            r_popped <= n_popped;
            r_closed <= n_closed;
            r_error  <= n_error;
            if (i_cfg_wr) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    bbsf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_byte),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    // Output register: the stream state is stable from execute until load.
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_front_byte;
    logic              r_front_valid;
    logic              r_out_accepted;
    logic [CAP_W-1:0]  r_buffered;
    logic [CAP_W-1:0]  r_free;
    logic [TOT_W-1:0]  r_out_pushed;
    logic [TOT_W-1:0]  r_out_popped;
    logic              r_out_closed;
    logic              r_finished;
    logic              r_out_error;
    logic              front_ok;

    assign front_ok          = (r_fill != '0);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_front_byte   <= front_ok ? rd_data : '0;
            r_front_valid  <= front_ok;
            r_out_accepted <= r_accepted;
            r_buffered     <= CAP_W'(fill_e);
            r_free         <= CAP_W'(free_e);
            r_out_pushed   <= r_pushed;
            r_out_popped   <= r_popped;
            r_out_closed   <= r_closed;
            r_finished     <= r_closed && (r_pushed == r_popped);
            r_out_error    <= r_error;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_front_byte     = r_front_byte;
    assign o_front_valid    = r_front_valid;
    assign o_accepted       = r_out_accepted;
    assign o_buffered_count = r_buffered;
    assign o_free_space     = r_free;
    assign o_pushed_total   = r_out_pushed;
    assign o_popped_total   = r_out_popped;
    assign o_closed         = r_out_closed;
    assign o_finished       = r_finished;
    assign o_error          = r_out_error;

endmodule

### src/bounded_byte_stream_fifo_unit.sv
// Bounded byte stream FIFO with writer close; one result per operation.
// Each operation runs execute, front-byte read and load around the single
// registered read port of the store; load waits while a stalled result holds
// the output register, and no new operation is taken until the load is done.
// Reset (synchronous, active low) clears pointers, counters and flags and sets
// capacity to 4096; the byte store is not cleared and no clearing pass runs.
module bounded_byte_stream_fifo_unit
    import bbsf_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [CAP_W-1:0]  i_pop_length,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CAP_W-1:0]  i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_front_byte,
    output logic              o_front_valid,
    output logic              o_accepted,
    output logic [CAP_W-1:0]  o_buffered_count,
    output logic [CAP_W-1:0]  o_free_space,
    output logic [TOT_W-1:0]  o_pushed_total,
    output logic [TOT_W-1:0]  o_popped_total,
    output logic              o_closed,
    output logic              o_finished,
    output logic              o_error
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    bbsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bbsf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_opcode         (i_opcode),
        .i_data_byte      (i_data_byte),
        .i_pop_length     (i_pop_length),
        .i_cfg_wr         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_front_byte     (o_front_byte),
        .o_front_valid    (o_front_valid),
        .o_accepted       (o_accepted),
        .o_buffered_count (o_buffered_count),
        .o_free_space     (o_free_space),
        .o_pushed_total   (o_pushed_total),
        .o_popped_total   (o_popped_total),
        .o_closed         (o_closed),
        .o_finished       (o_finished),
        .o_error          (o_error)
    );

    // One operation at a time: a transaction always stalls the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an operation is in flight");

    a_front_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_front_valid == (o_buffered_count != '0)))
        else $error("front valid disagrees with buffered count");

    a_finished_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_finished) |-> (o_closed && !o_front_valid))
        else $error("finished reported with bytes still held");

    a_accept_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (!o_closed && !o_error))
        else $error("push stored after close");

endmodule
